[hw/rtl/tbs_pkg.sv]
// tbs_pkg: shared types and constants for trace_background_subtract.
// No dependencies; imported by tbs_ctrl, tbs_dp and the top level.
`default_nettype none

package tbs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 8;
    localparam int RESID_W    = 25;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int FW_CFG_W   = 5;
    localparam int TL_CFG_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED     = 2'd2;

    localparam logic [FW_CFG_W-1:0] FILTER_WIDTH_RST = 5'd3;
    localparam logic [TL_CFG_W-1:0] TRACE_LENGTH_RST = 7'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_TAPS,
        S_DRAIN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic sum;
        logic tap;
        logic prep;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic use_taps;
        logic tap_last;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/tbs_ctrl.sv]
// tbs_ctrl: sequencing state machine for one item at a time.
// Depends on tbs_pkg (t_state, t_cmd, t_status).
`default_nettype none

module tbs_ctrl import tbs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SUM;
            end
            S_SUM: begin
                n_state = i_status.use_taps ? S_TAPS : S_PREP;
            end
            S_TAPS: begin
                if (i_status.tap_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_SUM:   o_cmd.sum = 1'b1;
            S_TAPS:  o_cmd.tap = 1'b1;
            S_DRAIN: o_cmd     = '0;
            S_PREP:  o_cmd.prep = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_OUT:   o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/tbs_dp.sv]
// tbs_dp: history and running-sum memories, weighted MAC, restoring divider,
// output register. Depends on tbs_pkg; driven by tbs_ctrl commands.
`default_nettype none

module tbs_dp import tbs_pkg::*; #(
    parameter int MAX_WIDTH = 16,
    parameter int MAX_TRACE = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic [FW_CFG_W-1:0]        i_filter_width,
    input  wire logic [TL_CFG_W-1:0]        i_trace_length,
    input  wire logic                       i_weighted,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic signed [RESID_W-1:0]       o_residual,
    output logic                            o_trace_end
);

    localparam int SW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW      = (MAX_TRACE > 1) ? $clog2(MAX_TRACE) : 1;
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int LW      = $clog2(MAX_TRACE + 1);
    localparam int DEPTH   = MAX_WIDTH * MAX_TRACE;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RSW     = SAMPLE_W + 1 + ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 0);
    localparam int DEN_MAX = MAX_WIDTH * (MAX_WIDTH + 1) / 2;
    localparam int DW      = $clog2(DEN_MAX + 1);
    localparam int NUMW    = SAMPLE_W + DW + 1;
    localparam int MAGW    = NUMW + FRAC_BITS;
    localparam int CNTW    = $clog2(MAGW + 1);
    localparam int SLW     = SW + 2;
    localparam int RW      = MAGW + 2;

    // effective configuration
    logic [WW-1:0] w;
    logic [LW-1:0] len;

    always_comb begin
        if (i_filter_width == '0) begin
            w = WW'(1);
        end else if (32'(i_filter_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_filter_width);
        end
        if (i_trace_length == '0) begin
            len = LW'(1);
        end else if (32'(i_trace_length) > MAX_TRACE) begin
            len = LW'(MAX_TRACE);
        end else begin
            len = LW'(i_trace_length);
        end
    end

    // window state
    logic [PW-1:0] r_pos;
    logic [WW-1:0] r_fill;
    logic [SW-1:0] r_oldest;

    logic [WW-1:0]  fill_eff;
    logic           full;
    logic [SLW-1:0] slot_sum;
    logic [SW-1:0]  new_slot;
    logic           last;
    logic [WW-1:0]  m_taps;

    always_comb begin
        fill_eff = (r_fill > w) ? w : r_fill;
        full     = (fill_eff == w);
        slot_sum = SLW'(r_oldest) + SLW'(fill_eff);
        new_slot = (slot_sum >= SLW'(MAX_WIDTH)) ? SW'(slot_sum - SLW'(MAX_WIDTH))
                                                 : SW'(slot_sum);
        last     = ((LW + 1)'(r_pos) + (LW + 1)'(1)) == (LW + 1)'(len);
        m_taps   = (fill_eff < (w - WW'(1))) ? fill_eff : (w - WW'(1));
    end

    function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
        slot_prev = (s == '0) ? SW'(MAX_WIDTH - 1) : (s - SW'(1));
    endfunction

    // memories
    logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
    logic signed [RSW-1:0]      rs_mem   [MAX_TRACE];
    logic signed [SAMPLE_W-1:0] r_hist_q;
    logic signed [RSW-1:0]      r_rs_q;

    logic signed [SAMPLE_W-1:0] r_x;
    logic [SW-1:0]              r_tap_slot;
    logic [SW-1:0]              rd_slot;
    logic [AW-1:0]              hist_raddr;
    logic [AW-1:0]              hist_waddr;

    always_comb begin
        rd_slot    = i_cmd.tap ? r_tap_slot : r_oldest;
        hist_raddr = AW'(rd_slot) * AW'(MAX_TRACE) + AW'(r_pos);
        hist_waddr = AW'(new_slot) * AW'(MAX_TRACE) + AW'(r_pos);
    end

    logic signed [RSW-1:0] new_sum;

    always_comb begin
        new_sum = ((r_fill == '0) ? RSW'(0) : r_rs_q) + RSW'(r_x)
                - (full ? RSW'(r_hist_q) : RSW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            hist_mem[hist_waddr] <= r_x;
            rs_mem[r_pos]        <= new_sum;
        end
        r_hist_q <= hist_mem[hist_raddr];
        r_rs_q   <= rs_mem[r_pos];
    end

    // accumulate: weighted taps, one per cycle, each added in the cycle after its history read
    logic signed [NUMW-1:0] r_acc;
    logic [DW-1:0]          r_den;
    logic [WW-1:0]          r_coef;
    logic [WW-1:0]          r_tap_left;
    logic                   r_tap_vld;
    logic [WW-1:0]          r_tap_coef;

    logic signed [NUMW-1:0] w_s;
    logic signed [NUMW-1:0] x_s;
    logic signed [NUMW-1:0] c_s;
    logic signed [NUMW-1:0] h_s;

    always_comb begin
        w_s = NUMW'(w);
        x_s = NUMW'(r_x);
        c_s = NUMW'(r_tap_coef);
        h_s = NUMW'(r_hist_q);
    end

    // divider
    logic                  r_neg;
    logic [MAGW-1:0]       r_dvd;
    logic [DW-1:0]         r_rem;
    logic [CNTW-1:0]       r_cnt;
    logic [DW:0]           trial;
    logic [NUMW-1:0]       acc_mag;

    always_comb begin
        trial   = {r_rem, r_dvd[MAGW-1]};
        acc_mag = r_acc[NUMW-1] ? NUMW'(-r_acc) : NUMW'(r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_sample;
        end
        r_tap_vld <= i_cmd.tap;
        if (i_cmd.sum) begin
            r_acc      <= i_weighted ? NUMW'(w_s * x_s) : NUMW'(new_sum);
            r_den      <= (i_weighted || full) ? DW'(w) : DW'(fill_eff + WW'(1));
            r_tap_slot <= slot_prev(new_slot);
            r_tap_left <= m_taps;
            r_coef     <= w - WW'(1);
        end else begin
            if (i_cmd.tap) begin
                r_tap_coef <= r_coef;
                r_coef     <= r_coef - WW'(1);
                r_tap_slot <= slot_prev(r_tap_slot);
                r_tap_left <= r_tap_left - WW'(1);
            end
            if (r_tap_vld) begin
                r_acc <= r_acc + NUMW'(c_s * h_s);
                r_den <= r_den + DW'(r_tap_coef);
            end
        end
        if (i_cmd.prep) begin
            r_neg <= r_acc[NUMW-1];
            r_dvd <= MAGW'(acc_mag) << FRAC_BITS;
            r_rem <= '0;
            r_cnt <= CNTW'(MAGW);
        end else if (i_cmd.div_step && (r_cnt != '0)) begin
            if (trial >= (DW + 1)'(r_den)) begin
                r_rem <= DW'(trial - (DW + 1)'(r_den));
                r_dvd <= {r_dvd[MAGW-2:0], 1'b1};
            end else begin
                r_rem <= DW'(trial);
                r_dvd <= {r_dvd[MAGW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    // result and output register
    logic signed [RW-1:0] quot_s;
    logic signed [RW-1:0] res_full;
    logic                 out_free;
    logic                 r_out_vld;

    always_comb begin
        quot_s   = r_neg ? -RW'(r_dvd) : RW'(r_dvd);
        res_full = (RW'(r_x) <<< FRAC_BITS) - quot_s;
        out_free = !r_out_vld || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_residual  <= res_full[RESID_W-1:0];
            o_trace_end <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_oldest  <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_clear) begin
                r_pos    <= '0;
                r_fill   <= '0;
                r_oldest <= '0;
            end else if (i_cmd.out_load) begin
                if (last) begin
                    r_pos <= '0;
                    if (!full) begin
                        r_fill <= fill_eff + WW'(1);
                    end else begin
                        r_fill   <= w;
                        r_oldest <= (r_oldest == SW'(MAX_WIDTH - 1)) ? '0
                                                                     : r_oldest + SW'(1);
                    end
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    always_comb begin
        o_status.use_taps = i_weighted && (m_taps != '0);
        o_status.tap_last = (r_tap_left == WW'(1));
        o_status.div_done = (r_cnt == '0);
        o_status.out_free = out_free;
        o_out_valid       = r_out_vld;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w)
        else $error("fill count above window width");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW + 1)'(r_pos) < (LW + 1)'(len))
        else $error("sample position beyond trace length");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_den != '0))
        else $error("divide by zero");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || !i_out_stall))
        else $error("result overwrote a pending item");

endmodule

`default_nettype wire

[hw/rtl/trace_background_subtract.sv]
// trace_background_subtract: top level, configuration registers, controller
// and datapath. Depends on tbs_pkg, tbs_ctrl and tbs_dp.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  input     in         i_in_valid / o_in_stall   i_sample (16b signed)
//  output    out        o_out_valid / i_out_stall o_residual (25b s, 8 frac),
//                                                 o_trace_end
//  config    in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// One item in flight. Weighted mode adds a tap walk over m older traces
// (m at most width - 1); MAGW is the dividend width of the bit-serial
// restoring divider, 33 at the defaults. The divider dominates the time
// per item, and the single history read port paces the weighted tap walk.
// Reset is synchronous, active low; it restores the register defaults and an
// empty window. The history memory is never cleared: entries are read only
// after being written, and running sums of the first trace ignore memory.
// A stalled result waits in the output register; the next item is taken
// meanwhile and held in the final state until the register frees up.
`default_nettype none

module trace_background_subtract import tbs_pkg::*; #(
    parameter int MAX_WIDTH = 16,
    parameter int MAX_TRACE = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [RESID_W-1:0]       o_residual,
    output logic                            o_trace_end,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [FW_CFG_W-1:0] r_filter_width;
    logic [TL_CFG_W-1:0] r_trace_length;
    logic                r_weighted;
    logic                cfg_hit;

    // any write to a known register restarts the filter from empty
    always_comb begin
        case (i_cfg_index)
            REG_FILTER_WIDTH: cfg_hit = i_cfg_wr_en;
            REG_TRACE_LENGTH: cfg_hit = i_cfg_wr_en;
            REG_WEIGHTED:     cfg_hit = i_cfg_wr_en;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_width <= FILTER_WIDTH_RST;
            r_trace_length <= TRACE_LENGTH_RST;
            r_weighted     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_FILTER_WIDTH: r_filter_width <= i_cfg_data[FW_CFG_W-1:0];
                REG_TRACE_LENGTH: r_trace_length <= i_cfg_data[TL_CFG_W-1:0];
                REG_WEIGHTED:     r_weighted     <= i_cfg_data[0];
                default:          r_weighted     <= r_weighted;
            endcase
        end
    end

    t_cmd    cmd;
    t_status status;

    tbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tbs_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TRACE (MAX_TRACE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (cfg_hit),
        .i_filter_width (r_filter_width),
        .i_trace_length (r_trace_length),
        .i_weighted     (r_weighted),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_residual     (o_residual),
        .o_trace_end    (o_trace_end)
    );

endmodule

`default_nettype wire
